>>> rtl/chacha8_keystream_xor_assert.svh
// assertion macros used by chacha8_keystream_xor.sv, clocked on clk with rst_n low as reset
`ifndef CHACHA8_KEYSTREAM_XOR_ASSERT_SVH
`define CHACHA8_KEYSTREAM_XOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define C8KX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define C8KX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/c8kx_pkg.sv
package c8kx_pkg;

  localparam int unsigned NUM_WORDS   = 16;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ROUNDS      = 8;
  localparam int unsigned CFG_AW      = 6;

  // register indexes, one 64-bit slot each
  localparam logic [2:0] REG_KEY_A         = 3'd0;
  localparam logic [2:0] REG_KEY_B         = 3'd1;
  localparam logic [2:0] REG_KEY_C         = 3'd2;
  localparam logic [2:0] REG_KEY_D         = 3'd3;
  localparam logic [2:0] REG_NONCE_LOW     = 3'd4;
  localparam logic [2:0] REG_NONCE_HIGH    = 3'd5;
  localparam logic [2:0] REG_START_COUNTER = 3'd6;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  typedef struct packed {
    logic [63:0] key_word_a;
    logic [63:0] key_word_b;
    logic [63:0] key_word_c;
    logic [63:0] key_word_d;
    logic [63:0] nonce_low;
    logic [31:0] nonce_high;
    logic [63:0] start_counter;
  } c8kx_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_DIAG,
    ST_UNDIAG,
    ST_FINAL,
    ST_EMIT
  } c8kx_state_t;

  // idx[1:0] is the quarter-round step, idx[3:2] the column; in ST_FINAL idx is the word
  typedef struct packed {
    c8kx_state_t state;
    logic [3:0]  idx;
  } c8kx_ctl_t;

  function automatic logic [31:0] c8kx_init_word(c8kx_cfg_t cfg, logic [31:0] ctr,
                                                 logic [31:0] ctrn, logic [3:0] idx);
    logic [31:0] w;
    unique case (idx)
      4'd0:  w = SIGMA_0;
      4'd1:  w = SIGMA_1;
      4'd2:  w = SIGMA_2;
      4'd3:  w = SIGMA_3;
      4'd4:  w = cfg.key_word_a[31:0];
      4'd5:  w = cfg.key_word_a[63:32];
      4'd6:  w = cfg.key_word_b[31:0];
      4'd7:  w = cfg.key_word_b[63:32];
      4'd8:  w = cfg.key_word_c[31:0];
      4'd9:  w = cfg.key_word_c[63:32];
      4'd10: w = cfg.key_word_d[31:0];
      4'd11: w = cfg.key_word_d[63:32];
      4'd12: w = ctr;
      4'd13: w = ctrn;
      4'd14: w = cfg.nonce_low[63:32];
      4'd15: w = cfg.nonce_high;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/c8kx_in_if.sv
interface c8kx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       end_of_message;

  modport source (output valid, output data_in, output end_of_message, input ready);
  modport sink (input valid, input data_in, input end_of_message, output ready);
endinterface

>>> rtl/c8kx_out_if.sv
interface c8kx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last;

  modport source (output valid, output data_out, output last, input ready);
  modport sink (input valid, input data_out, input last, output ready);
endinterface

>>> rtl/c8kx_regs.sv
module c8kx_regs import c8kx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready,
  output c8kx_cfg_t         cfg,
  output c8kx_cfg_t         cfg_nxt,
  output logic              reload
);

  c8kx_cfg_t  cfg_r;
  logic       wr;
  logic [2:0] idx;

  assign idx        = cfg_paddr[CFG_AW-1:3];
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;
  // writes past the register list are dropped and leave the counter alone
  assign reload     = wr && (idx <= REG_START_COUNTER);

  // register contents including the word being written this cycle
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_KEY_A:         cfg_nxt.key_word_a    = cfg_pwdata;
        REG_KEY_B:         cfg_nxt.key_word_b    = cfg_pwdata;
        REG_KEY_C:         cfg_nxt.key_word_c    = cfg_pwdata;
        REG_KEY_D:         cfg_nxt.key_word_d    = cfg_pwdata;
        REG_NONCE_LOW:     cfg_nxt.nonce_low     = cfg_pwdata;
        REG_NONCE_HIGH:    cfg_nxt.nonce_high    = cfg_pwdata[31:0];
        REG_START_COUNTER: cfg_nxt.start_counter = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_A:         cfg_prdata = cfg_r.key_word_a;
      REG_KEY_B:         cfg_prdata = cfg_r.key_word_b;
      REG_KEY_C:         cfg_prdata = cfg_r.key_word_c;
      REG_KEY_D:         cfg_prdata = cfg_r.key_word_d;
      REG_NONCE_LOW:     cfg_prdata = cfg_r.nonce_low;
      REG_NONCE_HIGH:    cfg_prdata = {32'd0, cfg_r.nonce_high};
      REG_START_COUNTER: cfg_prdata = cfg_r.start_counter;
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

>>> rtl/c8kx_qr_unit.sv
module c8kx_qr_unit import c8kx_pkg::*; (
  input  logic [31:0] x,
  input  logic [31:0] y,
  input  logic [31:0] z,
  input  logic [1:0]  step,
  output logic [31:0] sum,
  output logic [31:0] mix
);

  logic [31:0] t;

  // one quarter-round step: x += y; z = rotl(z ^ x, s)
  assign sum = x + y;
  assign t   = z ^ sum;

  always_comb begin
    unique case (step)
      2'd0: mix = {t[15:0], t[31:16]};
      2'd1: mix = {t[19:0], t[31:20]};
      2'd2: mix = {t[23:0], t[31:24]};
      2'd3: mix = {t[24:0], t[31:25]};
    endcase
  end

endmodule

>>> rtl/c8kx_seq.sv
module c8kx_seq import c8kx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output c8kx_ctl_t ctl,
  output logic      idle
);

  c8kx_state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [2:0]  rnd_r, rnd_nxt;
  logic        col_done;

  assign col_done = (cnt_r == 4'hf);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (col_done) state_nxt = rnd_r[0] ? ST_UNDIAG : ST_DIAG;
      end
      ST_DIAG:   state_nxt = ST_ROUND;
      ST_UNDIAG: begin
        state_nxt = (rnd_r == 3'(ROUNDS - 1)) ? ST_FINAL : ST_ROUND;
      end
      ST_FINAL:  if (col_done) state_nxt = ST_EMIT;
      ST_EMIT:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // odd rounds work on diagonals and are bracketed by the row shuffles
  always_comb begin
    cnt_nxt = cnt_r;
    rnd_nxt = rnd_r;
    unique case (state_r)
      ST_LOAD: begin
        cnt_nxt = '0;
        rnd_nxt = '0;
      end
      ST_ROUND: begin
        cnt_nxt = cnt_r + 4'd1;
        if (col_done && !rnd_r[0]) rnd_nxt = rnd_r + 3'd1;
      end
      ST_UNDIAG: rnd_nxt = rnd_r + 3'd1;
      ST_FINAL:  cnt_nxt = cnt_r + 4'd1;
      default: ;
    endcase
  end

  always_comb begin
    ctl.state = state_r;
    ctl.idx   = cnt_r;
    idle      = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

endmodule

>>> rtl/chacha8_keystream_xor.sv
// chacha8 keystream xor: each byte word taken on in_ch leaves on out_ch xored with the
// next keystream byte; end_of_message is copied to last. key, nonce and start counter
// are written through the cfg_ apb port (64-bit slots at 8*i); any write to a register
// reloads the block counter and discards the rest of the current keystream block.
// a byte inside a block is accepted whenever the output register is empty or being
// taken and appears on out_ch the next cycle, so one byte per cycle is sustained.
// a byte that needs a fresh block is held while the block is computed: a load,
// 128 quarter-round steps, 8 row shuffles, 16 feed-forward adds and an emit, after
// which its result appears on out_ch. the block time is set by the single
// add-xor-rotate unit, which does one quarter-round step per cycle on the 16-word
// state registers. in_ch.ready stays low during block generation.
// reset clears the registers, loads counter zero and forces a new block before the
// first byte. if out_ch stalls, the result stays in the output register and no new
// byte is taken until it is accepted.
`include "chacha8_keystream_xor_assert.svh"

module chacha8_keystream_xor import c8kx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  c8kx_in_if.sink           in_ch,
  c8kx_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);

  c8kx_cfg_t   cfg;
  c8kx_cfg_t   cfg_nxt;
  logic        reload;
  c8kx_ctl_t   ctl;
  logic        seq_idle;

  logic [31:0] w_r   [NUM_WORDS];
  logic [31:0] w_nxt [NUM_WORDS];
  logic [31:0] upd_w [NUM_WORDS];

  logic [6:0]  pos_r, pos_nxt;
  logic [31:0] ctr_r, ctr_nxt;
  logic [31:0] ctrn_r, ctrn_nxt;
  logic [31:0] ctr_inc;
  logic [7:0]  hold_data_r;
  logic        hold_last_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic        out_valid_r;

  logic        in_acc;
  logic        exhausted;
  logic        start;
  logic        out_load;
  logic [31:0] rd_word;
  logic [31:0] rd_shift;
  logic [31:0] alu_x, alu_y, alu_z, alu_sum, alu_mix;

  c8kx_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .cfg_nxt     (cfg_nxt),
    .reload      (reload)
  );

  c8kx_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ctl   (ctl),
    .idle  (seq_idle)
  );

  c8kx_qr_unit u_qr (
    .x    (alu_x),
    .y    (alu_y),
    .z    (alu_z),
    .step (ctl.idx[1:0]),
    .sum  (alu_sum),
    .mix  (alu_mix)
  );

  assign exhausted   = (pos_r == 7'(BLOCK_BYTES));
  assign in_ch.ready = seq_idle & (!out_valid_r | out_ch.ready);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign start       = in_acc & exhausted;
  assign out_load    = (in_acc & !exhausted) | (ctl.state == ST_EMIT);

  assign rd_word  = w_r[pos_r[5:2]];
  assign rd_shift = rd_word >> {pos_r[1:0], 3'b000};

  // in the round steps, column 0 of the 4x4 state is always the quarter-round being worked on
  always_comb begin
    if (ctl.state == ST_FINAL) begin
      alu_x = w_r[0];
      alu_y = c8kx_init_word(cfg, ctr_r, ctrn_r, ctl.idx);
      alu_z = w_r[12];
    end else if (ctl.idx[0]) begin
      alu_x = w_r[8];
      alu_y = w_r[12];
      alu_z = w_r[4];
    end else begin
      alu_x = w_r[0];
      alu_y = w_r[4];
      alu_z = w_r[12];
    end
  end

  always_comb begin
    upd_w = w_r;
    w_nxt = w_r;
    unique case (ctl.state)
      ST_LOAD: begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          w_nxt[i] = c8kx_init_word(cfg, ctr_r, ctrn_r, 4'(i));
        end
      end
      ST_ROUND: begin
        if (ctl.idx[0]) begin
          upd_w[8] = alu_sum;
          upd_w[4] = alu_mix;
        end else begin
          upd_w[0]  = alu_sum;
          upd_w[12] = alu_mix;
        end
        // last step of a quarter-round brings the next column into place
        if (ctl.idx[1:0] == 2'd3) begin
          for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
              w_nxt[4*r+j] = upd_w[4*r+((j+1)%4)];
            end
          end
        end else begin
          w_nxt = upd_w;
        end
      end
      ST_DIAG: begin
        for (int r = 0; r < 4; r++) begin
          for (int j = 0; j < 4; j++) begin
            w_nxt[4*r+j] = w_r[4*r+((j+r)%4)];
          end
        end
      end
      ST_UNDIAG: begin
        for (int r = 0; r < 4; r++) begin
          for (int j = 0; j < 4; j++) begin
            w_nxt[4*r+j] = w_r[4*r+((j+4-r)%4)];
          end
        end
      end
      ST_FINAL: begin
        // feed-forward add on word 0, then the whole state rotates by one word
        upd_w[0] = alu_sum;
        for (int i = 0; i < NUM_WORDS; i++) begin
          w_nxt[i] = upd_w[(i+1)%NUM_WORDS];
        end
      end
      default: ;
    endcase
  end

  assign ctr_inc = ctr_r + 32'd1;

  always_comb begin
    ctr_nxt  = ctr_r;
    ctrn_nxt = ctrn_r;
    pos_nxt  = pos_r;
    priority if (reload) begin
      // counter words come from the registers as they stand after this write
      ctr_nxt  = cfg_nxt.start_counter[31:0];
      ctrn_nxt = cfg_nxt.nonce_low[31:0] + cfg_nxt.start_counter[63:32];
      pos_nxt  = 7'(BLOCK_BYTES);
    end else if (ctl.state == ST_EMIT) begin
      ctr_nxt  = ctr_inc;
      ctrn_nxt = (ctr_inc == '0) ? ctrn_r + 32'd1 : ctrn_r;
      pos_nxt  = 7'd1;
    end else if (in_acc && !exhausted) begin
      pos_nxt = pos_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 7'(BLOCK_BYTES);
      ctr_r       <= '0;
      ctrn_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      ctr_r  <= ctr_nxt;
      ctrn_r <= ctrn_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    // the word waits here while its block is computed
    if (start) begin
      hold_data_r <= in_ch.data_in;
      hold_last_r <= in_ch.end_of_message;
    end
    if (ctl.state == ST_EMIT) begin
      out_data_r <= hold_data_r ^ w_r[0][7:0];
      out_last_r <= hold_last_r;
    end else if (out_load) begin
      out_data_r <= in_ch.data_in ^ rd_shift[7:0];
      out_last_r <= in_ch.end_of_message;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.last     = out_last_r;

  `C8KX_ASSERT_IMPL(a_busy_only_when_exhausted, ctl.state != ST_IDLE,
                    pos_r == 7'(BLOCK_BYTES), "block generation with keystream left")
  `C8KX_ASSERT_NEXT(a_exhausted_accept_starts, in_acc && exhausted,
                    ctl.state == ST_LOAD, "exhausted word did not start a block")
  `C8KX_ASSERT_NEXT(a_emit_fills_output, ctl.state == ST_EMIT,
                    out_valid_r && pos_r == 7'd1, "held word not delivered after block")

endmodule
